FILE: design/bsq_pkg.sv
// Shared types and codes for the bounded sorted priority queue.
package bsq_pkg;

  typedef struct packed {
    logic [7:0]         label;
    logic signed [15:0] priority_val;
    logic signed [15:0] time_val;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   ins;
  } cell_cmd_t;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_SERVICE = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic signed [15:0] PRIO_FLOOR = 16'sh8000;

endpackage

FILE: design/bsq_cell.sv
// One slot of the sorted chain: holds an entry and trades with its neighbors.
module bsq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  bsq_pkg::cell_cmd_t cmd,
  input  logic              left_displace,
  input  bsq_pkg::entry_t   left_entry,
  input  logic              left_valid,
  input  bsq_pkg::entry_t   right_entry,
  input  logic              right_valid,
  output bsq_pkg::entry_t   entry,
  output logic              valid,
  output logic              displace
);
  import bsq_pkg::*;

  entry_t entry_r, entry_nxt;
  logic   valid_r, valid_nxt;

  // this slot gives way when it is empty or holds a strictly larger priority
  assign displace = !valid_r || (entry_r.priority_val > cmd.ins.priority_val);

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    case (cmd.op)
      CELL_INSERT: begin
        if (displace) begin
          if (left_displace) begin
            entry_nxt = left_entry;
            valid_nxt = left_valid;
          end else begin
            entry_nxt = cmd.ins;
            valid_nxt = 1'b1;
          end
        end
      end
      CELL_POP: begin
        entry_nxt = right_entry;
        valid_nxt = right_valid;
      end
      default: begin
        entry_nxt = entry_r;
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign valid = valid_r;

endmodule

FILE: design/bounded_sorted_priority_queue.sv
// Top level of the bounded sorted priority queue built as a chain of slot cells.
//
// Holds up to min(capacity, DEPTH) entries in a row of DEPTH cells, sorted by
// ascending priority with the head in cell 0. An insert is presented to every
// cell at once: each cell compares its priority with the new one and either keeps
// its entry, takes the new one, or takes its left neighbor's. A service first
// shifts every cell left and holds the old head with its priority lowered by one
// (saturating at -32768), then inserts it again. After that, the report state
// loads the result register once the output is free. Items are handled one at a
// time; a new item is taken while the previous result still waits on the output,
// and its report step then holds until that result is taken.
// Each item gives exactly one result with status, count and head (zero when empty).
module bounded_sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // cfg_wdata: capacity
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  // in_tdata: priority_req [15:0], time_value [31:16], label [39:32]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,
  // in_tuser: op
  input  logic [0:0]  in_tuser,
  // out_tdata: count [4:0], head_label [12:5], head_priority [28:13],
  //            head_time [44:29], zero [47:45]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  // out_tuser: status
  output logic [1:0]  out_tuser
);
  import bsq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_REINS,
    S_REPORT
  } state_t;

  state_t         state_r, state_nxt;
  logic [4:0]     capacity_r;
  logic [CW-1:0]  count_r, count_nxt;
  logic [1:0]     status_r, status_nxt;
  entry_t         svc_r, svc_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [47:0]    out_data_r, out_data_nxt;
  logic [1:0]     out_user_r, out_user_nxt;

  cell_cmd_t      cmd;
  entry_t         in_entry;
  entry_t         cell_entry [DEPTH];
  logic           cell_valid [DEPTH];
  logic           cell_disp  [DEPTH];

  logic           accept;
  logic           full;
  logic [CW+4:0]  count_ext, cap_ext, depth_ext;
  logic           out_free;
  entry_t         head;

  assign in_entry.priority_val = in_tdata[15:0];
  assign in_entry.time_val     = in_tdata[31:16];
  assign in_entry.label        = in_tdata[39:32];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  assign count_ext = {5'd0, count_r};
  assign cap_ext   = {{CW{1'b0}}, capacity_r};
  assign depth_ext = (CW + 5)'(DEPTH);
  assign full      = (count_ext >= cap_ext) || (count_ext >= depth_ext);
  assign out_free  = !out_valid_r || out_tready;
  assign head      = cell_entry[0];

  // drive the chain
  always_comb begin
    cmd.op  = CELL_HOLD;
    cmd.ins = in_entry;
    if (state_r == S_REINS) begin
      cmd.op  = CELL_INSERT;
      cmd.ins = svc_r;
    end else if (accept) begin
      if (in_tuser[0] == OP_INSERT) begin
        if (!full) begin
          cmd.op = CELL_INSERT;
        end
      end else if (count_r != '0) begin
        cmd.op = CELL_POP;
      end
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic   l_disp;
      logic   l_valid;
      entry_t l_entry;
      logic   r_valid;
      entry_t r_entry;
      if (gi == 0) begin : g_first
        assign l_disp  = 1'b0;
        assign l_valid = 1'b0;
        assign l_entry = in_entry;
      end else begin : g_mid
        assign l_disp  = cell_disp[gi-1];
        assign l_valid = cell_valid[gi-1];
        assign l_entry = cell_entry[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign r_valid = 1'b0;
        assign r_entry = in_entry;
      end else begin : g_inner
        assign r_valid = cell_valid[gi+1];
        assign r_entry = cell_entry[gi+1];
      end
      bsq_cell u_cell (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .left_displace (l_disp),
        .left_entry    (l_entry),
        .left_valid    (l_valid),
        .right_entry   (r_entry),
        .right_valid   (r_valid),
        .entry         (cell_entry[gi]),
        .valid         (cell_valid[gi]),
        .displace      (cell_disp[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    status_nxt    = status_r;
    svc_nxt       = svc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt  = S_REPORT;
          status_nxt = ST_DONE;
          if (in_tuser[0] == OP_INSERT) begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              count_nxt = count_r + CW'(1);
            end
          end else if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            // hold the old head, lowered by one unless already at the floor
            svc_nxt = head;
            if (head.priority_val != PRIO_FLOOR) begin
              svc_nxt.priority_val = head.priority_val - 16'sd1;
            end
            state_nxt = S_REINS;
          end
        end
      end
      S_REINS: begin
        state_nxt = S_REPORT;
      end
      S_REPORT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = status_r;
          if (count_r == '0) begin
            out_data_nxt = {3'd0, 40'd0, count_ext[4:0]};
          end else begin
            out_data_nxt = {3'd0, head.time_val, head.priority_val, head.label,
                            count_ext[4:0]};
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      capacity_r  <= 5'd16;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
    end
    status_r   <= status_nxt;
    svc_r      <= svc_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bounded sorted priority queue stream block.
module tb;
  import bsq_pkg::*;

  localparam int SLOTS = 16;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         count;
    logic [7:0]         head_label;
    logic signed [15:0] head_prio;
    logic signed [15:0] head_tm;
  } report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;

  // Predicted queue contents, slot 0 is the head
  entry_t      slots [SLOTS];
  int          held = 0;
  logic [4:0]  cap_reg = 5'd16;

  report_t     pending_reports [$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          full_refusals = 0;
  int          empty_refusals = 0;
  int          cap_writes = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          stall_cycles = 0;

  bounded_sorted_priority_queue #(.DEPTH(SLOTS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Insert after every slot whose priority is at or below the new one
  function automatic void place_entry(entry_t e);
    int pos;
    int i;
    pos = 0;
    while (pos < held && slots[pos].priority_val <= e.priority_val) pos++;
    for (i = held; i > pos; i--) slots[i] = slots[i - 1];
    slots[pos] = e;
    held++;
  endfunction

  function automatic report_t apply_request(logic op, entry_t e);
    report_t r;
    entry_t  head;
    int      eff_cap;
    int      i;
    eff_cap = (cap_reg < SLOTS) ? int'(cap_reg) : SLOTS;
    r = '0;
    r.status = ST_DONE;
    if (op == OP_INSERT) begin
      if (held >= eff_cap) begin
        r.status = ST_FULL;
        full_refusals++;
      end else begin
        place_entry(e);
      end
    end else if (held == 0) begin
      r.status = ST_EMPTY;
      empty_refusals++;
    end else begin
      head = slots[0];
      // saturate at the floor instead of wrapping
      if (head.priority_val != PRIO_FLOOR) head.priority_val = head.priority_val - 16'sd1;
      for (i = 1; i < held; i++) slots[i - 1] = slots[i];
      held--;
      place_entry(head);
    end
    r.count = held[4:0];
    if (held > 0) begin
      r.head_label = slots[0].label;
      r.head_prio  = slots[0].priority_val;
      r.head_tm    = slots[0].time_val;
    end
    return r;
  endfunction

  task automatic note_mismatch(string what, report_t want, report_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%t mismatch (%s): expected st=%0d cnt=%0d lab=%0d pri=%0d tm=%0d",
               $realtime, what, want.status, want.count, want.head_label,
               want.head_prio, want.head_tm);
      $display("%t               actual   st=%0d cnt=%0d lab=%0d pri=%0d tm=%0d",
               $realtime, got.status, got.count, got.head_label, got.head_prio,
               got.head_tm);
    end
  endtask

  // Drive one item at the falling edge and hold it until accepted
  task automatic send_request(logic op, entry_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {e.label, e.time_val, e.priority_val};
    do @(posedge clk); while (!in_tready);
    pending_reports.push_back(apply_request(op, e));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_reports();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(logic [4:0] value);
    drain_reports();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cap_reg = value;
    cap_writes++;
  endtask

  function automatic entry_t make_entry(int prio, int tm, int lab);
    entry_t e;
    e.priority_val = prio[15:0];
    e.time_val     = tm[15:0];
    e.label        = lab[7:0];
    return e;
  endfunction

  task automatic test_directed_ops();
    send_request(OP_SERVICE, make_entry(5, 5, 5));            // refused on empty queue
    send_request(OP_INSERT, make_entry(0, 32767, 255));
    send_request(OP_SERVICE, make_entry(0, 0, 0));            // lone entry stays head
    send_request(OP_INSERT, make_entry(-32768, -32768, 0));
    send_request(OP_SERVICE, make_entry(0, 0, 0));            // head pinned at the floor
    send_request(OP_INSERT, make_entry(32767, 0, 1));
    send_request(OP_INSERT, make_entry(32767, 1, 2));         // tie lands behind
    send_request(OP_INSERT, make_entry(-1, -1, 8'h10));       // tie with a served entry
    send_request(OP_INSERT, make_entry(16'h5555, 16'haaaa, 8'h55));
    repeat (4) send_request(OP_SERVICE, make_entry(-1, -1, 255));
  endtask

  task automatic test_capacity_limits();
    write_capacity(5'd0);
    send_request(OP_INSERT, make_entry(3, 3, 3));              // nothing fits
    send_request(OP_SERVICE, make_entry(0, 0, 0));
    write_capacity(5'd2);                                      // below current count
    send_request(OP_INSERT, make_entry(-4, 4, 4));
    send_request(OP_SERVICE, make_entry(0, 0, 0));
    write_capacity(5'd31);                                     // clipped to storage size
    send_request(OP_INSERT, make_entry(-2, 7, 9));
    send_request(OP_SERVICE, make_entry(0, 0, 0));
    write_capacity(5'd16);
  endtask

  task automatic test_random_traffic(int n_items);
    entry_t e;
    logic   op;
    int     k;
    for (k = 0; k < n_items; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(6))
          0:       write_capacity(5'd0);
          1:       write_capacity(5'd1);
          2:       write_capacity(5'd16);
          3:       write_capacity(5'd31);
          4:       write_capacity(5'($urandom_range(2, 15)));
          5:       write_capacity(5'($urandom_range(17, 30)));
          default: write_capacity(5'($urandom_range(31)));
        endcase
      end
      op = ($urandom_range(99) < 45) ? OP_INSERT : OP_SERVICE;
      e.label    = 8'($urandom);
      e.time_val = 16'($urandom);
      // mostly clustered priorities so ties and reinsertion order get exercised
      case ($urandom_range(9))
        6, 7:    e.priority_val = 16'($urandom);
        8:       e.priority_val = PRIO_FLOOR + 16'($urandom_range(3));
        9:       e.priority_val = 16'sh7fff - 16'($urandom_range(3));
        default: e.priority_val = 16'($urandom_range(6)) - 16'sd3;
      endcase
      send_request(op, e);
    end
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_reports
    report_t got;
    report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status     = out_tuser;
      got.count      = out_tdata[4:0];
      got.head_label = out_tdata[12:5];
      got.head_prio  = out_tdata[28:13];
      got.head_tm    = out_tdata[44:29];
      results_seen++;
      if (pending_reports.size() == 0) begin
        note_mismatch("no result expected", '0, got);
      end else begin
        want = pending_reports.pop_front();
        if (got.status !== want.status || got.count !== want.count ||
            got.head_label !== want.head_label || got.head_prio !== want.head_prio ||
            got.head_tm !== want.head_tm) begin
          note_mismatch("field differs", want, got);
        end
      end
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", stall_cycles);
      $display("[bounded_sorted_priority_queue] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_ops();
    test_capacity_limits();

    send_idle_pct = 31;
    recv_idle_pct = 68;
    test_random_traffic(200);
    send_idle_pct = 68;
    recv_idle_pct = 31;
    test_random_traffic(200);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(200);

    drain_reports();
    repeat (8) @(negedge clk);
    while (pending_reports.size() != 0) begin
      note_mismatch("result never arrived", pending_reports.pop_front(), '0);
    end

    $display("covered %0d items, %0d results, %0d capacity writes",
             items_sent, results_seen, cap_writes);
    $display("refusals: %0d on full queue, %0d on empty queue; %0d mismatches",
             full_refusals, empty_refusals, mismatches);
    if (mismatches == 0) begin
      $display("[bounded_sorted_priority_queue] OK");
    end else begin
      $display("[bounded_sorted_priority_queue] ERROR");
    end
    $finish;
  end

endmodule
